>>> design/tls_client_hello_sni_extract_top_defines.svh
// Assertion macros used by the checker file.
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACT_TOP_DEFINES_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACT_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define TCS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcs checker: property violated");

// The consequent holds in the cycle after the antecedent.
`define TCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcs checker: property violated");

`endif

>>> design/tcs_pkg.sv
package tcs_pkg;

  // Record and handshake constants.
  localparam logic [7:0] CONTENT_HANDSHAKE = 8'h16;
  localparam logic [7:0] HS_CLIENT_HELLO   = 8'h01;
  localparam logic [7:0] NAME_TYPE_HOST    = 8'h00;
  localparam logic [7:0] MAJOR_SSL3        = 8'd3;
  localparam int unsigned HELLO_FIXED_END  = 43;
  localparam logic [7:0] MAX_NAME_RESET    = 8'd255;

  // Verdict codes.
  localparam logic [2:0] RSN_OK         = 3'd0;
  localparam logic [2:0] RSN_INCOMPLETE = 3'd1;
  localparam logic [2:0] RSN_NOT_HS     = 3'd2;
  localparam logic [2:0] RSN_OLD_VER    = 3'd3;
  localparam logic [2:0] RSN_NOT_HELLO  = 3'd4;
  localparam logic [2:0] RSN_OVERRUN    = 3'd5;
  localparam logic [2:0] RSN_NO_SNI     = 3'd6;
  localparam logic [2:0] RSN_SSL3_NOEXT = 3'd7;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_last;
  } item_t;

  typedef struct packed {
    logic       name_valid;
    logic [7:0] name_byte;
    logic       verdict_valid;
    logic       name_found;
    logic [7:0] name_length;
    logic [2:0] fail_reason;
  } result_t;

endpackage

>>> design/tcs_ifs.sv
interface tcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_last;
  modport source (output valid, output payload_byte, output payload_last, input ready);
  modport sink (input valid, input payload_byte, input payload_last, output ready);
endinterface

interface tcs_out_if;
  logic       valid;
  logic       ready;
  logic       name_valid;
  logic [7:0] name_byte;
  logic       verdict_valid;
  logic       name_found;
  logic [7:0] name_length;
  logic [2:0] fail_reason;
  modport source (output valid, output name_valid, output name_byte, output verdict_valid,
                  output name_found, output name_length, output fail_reason, input ready);
  modport sink (input valid, input name_valid, input name_byte, input verdict_valid,
                input name_found, input name_length, input fail_reason, output ready);
endinterface

interface tcs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_name_len;
  modport source (output valid, output max_name_len, input ready);
  modport sink (input valid, input max_name_len, output ready);
endinterface

>>> design/tls_client_hello_sni_extract_top.sv
// TLS ClientHello server-name extractor. Payload bytes enter a two-entry queue one per
// cycle unless it is full; the parser takes one byte per cycle from it unless its result
// is held and writes at most one result per byte into an output register, so the rate is
// one byte per cycle while the result side takes a transaction every cycle. Name bytes
// stream out as they arrive; a verdict ends each payload, and after it bytes are dropped
// until the byte flagged last. The user must write max_name_len only while the block is
// idle; the block itself does not enforce this. The reset value of max_name_len is 255.
module tls_client_hello_sni_extract_top #(
  parameter int unsigned NAME_MAX_BYTES = 255
) (
  input  logic clk_i,
  input  logic rst_ni,
  tcs_in_if.sink    payload_i,
  tcs_cfg_if.sink   cfg_i,
  tcs_out_if.source result_o
);
  import tcs_pkg::*;

  item_t      push_item, pop_item;
  result_t    res;
  logic       full, empty, pop, res_valid;
  logic [7:0] max_name_len_q;

  assign payload_i.ready = !full;
  assign push_item.payload_byte = payload_i.payload_byte;
  assign push_item.payload_last = payload_i.payload_last;
  assign cfg_i.ready = 1'b1;

  // Name limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_name_len_q <= MAX_NAME_RESET;
    end else if (cfg_i.valid) begin
      max_name_len_q <= cfg_i.max_name_len;
    end
  end

  tcs_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(payload_i.valid && !full), .push_item_i(push_item), .full_o(full),
    .pop_i(pop), .empty_o(empty), .pop_item_o(pop_item)
  );

  tcs_parser #(.NAME_MAX_BYTES(NAME_MAX_BYTES)) u_parser (
    .clk_i, .rst_ni,
    .in_valid_i(!empty), .in_item_i(pop_item), .in_pop_o(pop),
    .max_name_len_i(max_name_len_q),
    .out_valid_o(res_valid), .out_result_o(res), .out_ready_i(result_o.ready)
  );

  assign result_o.valid         = res_valid;
  assign result_o.name_valid    = res.name_valid;
  assign result_o.name_byte     = res.name_byte;
  assign result_o.verdict_valid = res.verdict_valid;
  assign result_o.name_found    = res.name_found;
  assign result_o.name_length   = res.name_length;
  assign result_o.fail_reason   = res.fail_reason;

endmodule

>>> design/tcs_queue.sv
module tcs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcs_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tcs_pkg::item_t pop_item_o
);
  import tcs_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_item_o = mem_q[rptr_q];

  // Two-entry queue between the byte intake and the parser.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_item_i;
  end

endmodule

>>> design/tcs_parser.sv
module tcs_parser #(
  parameter int unsigned NAME_MAX_BYTES = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  tcs_pkg::item_t   in_item_i,
  output logic             in_pop_o,
  input  logic [7:0]       max_name_len_i,
  output logic             out_valid_o,
  output tcs_pkg::result_t out_result_o,
  input  logic             out_ready_i
);
  import tcs_pkg::*;

  typedef enum logic [4:0] {
    PH_HDR, PH_HS_TYPE, PH_SID_LEN, PH_CS_HI, PH_CS_LO, PH_CM_LEN, PH_EXT_HI, PH_EXT_LO,
    PH_XT_HI, PH_XT_LO, PH_XL_HI_SNI, PH_XL_LO_SNI, PH_XL_HI_OTH, PH_XL_LO_OTH, PH_NT,
    PH_NL_HI_HOST, PH_NL_LO_HOST, PH_NL_HI_OTH, PH_NL_LO_OTH, PH_EMIT, PH_SKIP, PH_TAIL
  } phase_e;

  localparam logic [7:0] NameCap = 8'(NAME_MAX_BYTES);

  phase_e      ph_q, ph_d, res_q, res_d;
  logic [16:0] bp_q, bp_d, rend_q, rend_d, ext_q, ext_d, snie_q, snie_d;
  logic [15:0] frem_q, frem_d;
  logic [7:0]  acc_q, acc_d, minor_q, minor_d, emit_q, emit_d;
  logic [2:0]  pend_q, pend_d;
  logic        maj3_q, maj3_d, done_q, done_d;
  logic        out_valid_q;
  result_t     out_q, res_v;
  logic        step, res_en;

  logic [18:0] bpn, len, gq;
  logic [7:0]  b, lim;
  logic        do_fail, do_goto, verdict, name_out;
  logic [2:0]  freason, reason;
  phase_e      gph;

  assign step         = in_valid_i && (!out_valid_q || out_ready_i);
  assign in_pop_o     = step;
  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;
  assign lim          = (max_name_len_i < NameCap) ? max_name_len_i : NameCap;

  // Per-byte parse: phase transition, length checks and result assembly.
  always_comb begin
    ph_d = ph_q; res_d = res_q; bp_d = bp_q; rend_d = rend_q; ext_d = ext_q;
    snie_d = snie_q; frem_d = frem_q; acc_d = acc_q; minor_d = minor_q;
    emit_d = emit_q; pend_d = pend_q; maj3_d = maj3_q; done_d = done_q;
    b = in_item_i.payload_byte;
    bpn = {2'b0, bp_q} + 19'd1;
    len = {3'b0, acc_q, b};
    do_fail = 1'b0; freason = RSN_OK; do_goto = 1'b0; gq = '0; gph = PH_HDR;
    verdict = 1'b0; reason = RSN_OK; name_out = 1'b0; res_en = 1'b0; res_v = '0;

    if (!done_q) begin
      bp_d = bpn[16:0];
      case (ph_q)
        PH_HDR: begin
          case (bp_q[1:0])
            2'd0: if (bp_q[2]) begin
              rend_d = {1'b0, acc_q, b} + 17'd5;
              if (pend_q != RSN_OK) begin
                verdict = 1'b1; reason = pend_q; ph_d = PH_TAIL;
              end else if (rend_d < 17'd6) begin
                do_fail = 1'b1; freason = RSN_OVERRUN;
              end else begin
                ph_d = PH_HS_TYPE;
              end
            end else begin
              acc_d = b;
            end
            2'd1: begin
              if (acc_q != CONTENT_HANDSHAKE) pend_d = RSN_NOT_HS;
              else if (b < MAJOR_SSL3) pend_d = RSN_OLD_VER;
              else pend_d = RSN_OK;
              maj3_d = (b == MAJOR_SSL3);
            end
            2'd2: minor_d = b;
            default: acc_d = b;
          endcase
        end
        PH_HS_TYPE: begin
          if (b != HS_CLIENT_HELLO) begin
            do_fail = 1'b1; freason = RSN_NOT_HELLO;
          end else if (rend_q < 17'(HELLO_FIXED_END + 1)) begin
            do_fail = 1'b1; freason = RSN_OVERRUN;
          end else begin
            do_goto = 1'b1; gq = 19'(HELLO_FIXED_END); gph = PH_SID_LEN;
          end
        end
        PH_SID_LEN: begin
          if (bpn + {11'b0, b} + 19'd2 > {2'b0, rend_q}) begin
            do_fail = 1'b1; freason = RSN_OVERRUN;
          end else begin
            do_goto = 1'b1; gq = bpn + {11'b0, b}; gph = PH_CS_HI;
          end
        end
        PH_CS_HI:      begin acc_d = b; ph_d = PH_CS_LO; end
        PH_EXT_HI:     begin acc_d = b; ph_d = PH_EXT_LO; end
        PH_XT_HI:      begin acc_d = b; ph_d = PH_XT_LO; end
        PH_XL_HI_SNI:  begin acc_d = b; ph_d = PH_XL_LO_SNI; end
        PH_XL_HI_OTH:  begin acc_d = b; ph_d = PH_XL_LO_OTH; end
        PH_NL_HI_HOST: begin acc_d = b; ph_d = PH_NL_LO_HOST; end
        PH_NL_HI_OTH:  begin acc_d = b; ph_d = PH_NL_LO_OTH; end
        PH_CS_LO: begin
          if (bpn + len + 19'd1 > {2'b0, rend_q}) begin
            do_fail = 1'b1; freason = RSN_OVERRUN;
          end else begin
            do_goto = 1'b1; gq = bpn + len; gph = PH_CM_LEN;
          end
        end
        PH_CM_LEN: begin
          gq = bpn + {11'b0, b};
          if (gq == {2'b0, rend_q} && maj3_q && minor_q == 8'd0) begin
            do_fail = 1'b1; freason = RSN_SSL3_NOEXT;
          end else if (gq + 19'd2 > {2'b0, rend_q}) begin
            do_fail = 1'b1; freason = RSN_OVERRUN;
          end else begin
            do_goto = 1'b1; gph = PH_EXT_HI;
          end
        end
        PH_EXT_LO: begin
          if (bpn + len > {2'b0, rend_q}) begin
            do_fail = 1'b1; freason = RSN_OVERRUN;
          end else begin
            ext_d = 17'(bpn + len);
            gq = bpn;
            if (gq + 19'd4 <= {2'b0, ext_d}) begin
              do_goto = 1'b1; gph = PH_XT_HI;
            end else begin
              do_fail = 1'b1; freason = RSN_NO_SNI;
            end
          end
        end
        PH_XT_LO: ph_d = (len == 19'd0) ? PH_XL_HI_SNI : PH_XL_HI_OTH;
        PH_XL_LO_SNI: begin
          if (bpn + len > {2'b0, ext_q}) begin
            do_fail = 1'b1; freason = RSN_OVERRUN;
          end else begin
            snie_d = 17'(bpn + len);
            gq = bpn + 19'd2;
            if (gq + 19'd3 < {2'b0, snie_d}) begin
              do_goto = 1'b1; gph = PH_NT;
            end else begin
              do_fail = 1'b1; freason = RSN_NO_SNI;
            end
          end
        end
        PH_XL_LO_OTH: begin
          gq = bpn + len;
          if (gq + 19'd4 <= {2'b0, ext_q}) begin
            do_goto = 1'b1; gph = PH_XT_HI;
          end else begin
            do_fail = 1'b1; freason = RSN_NO_SNI;
          end
        end
        PH_NT: ph_d = (b == NAME_TYPE_HOST) ? PH_NL_HI_HOST : PH_NL_HI_OTH;
        PH_NL_LO_HOST: begin
          if (bpn + len > {2'b0, snie_q}) begin
            do_fail = 1'b1; freason = RSN_OVERRUN;
          end else if (len == 19'd0) begin
            do_fail = 1'b1; freason = RSN_OK;
          end else begin
            frem_d = len[15:0]; ph_d = PH_EMIT;
          end
        end
        PH_NL_LO_OTH: begin
          gq = bpn + len;
          if (gq > {2'b0, snie_q}) begin
            do_fail = 1'b1; freason = RSN_OVERRUN;
          end else if (gq + 19'd3 < {2'b0, snie_q}) begin
            do_goto = 1'b1; gph = PH_NT;
          end else begin
            do_fail = 1'b1; freason = RSN_NO_SNI;
          end
        end
        PH_EMIT: begin
          if (emit_q < lim) begin
            name_out = 1'b1; emit_d = emit_q + 8'd1;
          end
          frem_d = frem_q - 16'd1;
          if (frem_d == 16'd0) begin
            do_fail = 1'b1; freason = RSN_OK;
          end
        end
        PH_SKIP: begin
          frem_d = frem_q - 16'd1;
          if (frem_d == 16'd0) ph_d = res_q;
        end
        default: ;
      endcase

      // Fail to the tail phase, or jump to a later byte, through a skip count when it lies ahead.
      if (do_fail) begin
        pend_d = freason; ph_d = PH_TAIL;
      end else if (do_goto) begin
        if (gq <= bpn) begin
          ph_d = gph;
        end else begin
          frem_d = 16'(gq - bpn); res_d = gph; ph_d = PH_SKIP;
        end
      end

      if (!verdict && bpn >= 19'd5 && bpn == {2'b0, rend_d}) begin
        verdict = 1'b1;
        reason = (ph_d == PH_TAIL) ? pend_d : RSN_OVERRUN;
      end
      if (!verdict && in_item_i.payload_last) begin
        verdict = 1'b1; reason = RSN_INCOMPLETE;
      end

      res_en = name_out || verdict;
      res_v.name_valid = name_out;
      res_v.name_byte  = name_out ? b : 8'd0;
      if (verdict) begin
        res_v.verdict_valid = 1'b1;
        res_v.name_found    = (reason == RSN_OK);
        res_v.name_length   = emit_d;
        res_v.fail_reason   = reason;
        done_d = 1'b1;
      end
    end

    // Re-arm for the next payload on the last byte of this one, once its verdict is given.
    if (in_item_i.payload_last && (done_q || verdict)) begin
      ph_d = PH_HDR; res_d = PH_HDR; bp_d = '0; rend_d = '0; ext_d = '0; snie_d = '0;
      frem_d = '0; acc_d = '0; minor_d = '0; emit_d = '0; pend_d = RSN_OK;
      maj3_d = 1'b0; done_d = 1'b0;
    end
  end

  // Parse state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_HDR; res_q <= PH_HDR; bp_q <= '0; rend_q <= '0; ext_q <= '0;
      snie_q <= '0; frem_q <= '0; acc_q <= '0; minor_q <= '0; emit_q <= '0;
      pend_q <= RSN_OK; maj3_q <= 1'b0; done_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        ph_q <= ph_d; res_q <= res_d; bp_q <= bp_d; rend_q <= rend_d; ext_q <= ext_d;
        snie_q <= snie_d; frem_q <= frem_d; acc_q <= acc_d; minor_q <= minor_d;
        emit_q <= emit_d; pend_q <= pend_d; maj3_q <= maj3_d; done_q <= done_d;
      end
      if (step) out_valid_q <= res_en;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_en) out_q <= res_v;
  end

endmodule

>>> design/tcs_checker.sv
`include "tls_client_hello_sni_extract_top_defines.svh"

module tcs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic       name_valid,
  input logic [7:0] name_byte,
  input logic       verdict_valid,
  input logic       name_found,
  input logic [7:0] name_length,
  input logic [2:0] fail_reason
);
  import tcs_pkg::*;

  // Found and a zero reason go together on every verdict.
  `TCS_ASSERT_SAME(a_found_ok, out_valid && verdict_valid, name_found == (fail_reason == RSN_OK))
  // A result without a verdict carries cleared verdict fields.
  `TCS_ASSERT_SAME(a_no_verdict, out_valid && !verdict_valid, !name_found && name_length == 8'd0 && fail_reason == RSN_OK)
  // Every result carries a name byte or a verdict, and no stray byte.
  `TCS_ASSERT_SAME(a_nonempty, out_valid, (name_valid || verdict_valid) && (name_valid || name_byte == 8'd0))
  // A stalled result holds.
  `TCS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(name_byte) && $stable(verdict_valid))

endmodule

bind tls_client_hello_sni_extract_top tcs_checker u_tcs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid(result_o.valid), .out_ready(result_o.ready),
  .name_valid(result_o.name_valid), .name_byte(result_o.name_byte),
  .verdict_valid(result_o.verdict_valid), .name_found(result_o.name_found),
  .name_length(result_o.name_length), .fail_reason(result_o.fail_reason)
);

>>> tb/sv/tcs_tb_ifs.sv
`timescale 1ns / 100ps

// Channel interfaces are provided by the design; this file holds the stimulus
// channel shape used only by the test to bundle one payload byte.
package tcs_tb_pkg;

  typedef struct {
    logic [7:0] payload_byte;
    logic       payload_last;
  } payload_beat_t;

endpackage

>>> tb/sv/tls_client_hello_sni_extract_top_test.sv
`timescale 1ns / 100ps

module tls_client_hello_sni_extract_top_test;
  import tcs_pkg::*;
  import tcs_tb_pkg::*;

  // Parse phases of the predictor.
  typedef enum logic [4:0] {
    P_HDR, P_HS_TYPE, P_SID_LEN, P_CS_HI, P_CS_LO, P_CM_LEN, P_EXT_HI, P_EXT_LO,
    P_XT_HI, P_XT_LO, P_XL_HI_SNI, P_XL_LO_SNI, P_XL_HI_OTH, P_XL_LO_OTH, P_NT,
    P_NL_HI_HOST, P_NL_LO_HOST, P_NL_HI_OTH, P_NL_LO_OTH, P_EMIT, P_SKIP, P_TAIL
  } parse_phase_e;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tcs_in_if  payload_if ();
  tcs_cfg_if cfg_if ();
  tcs_out_if result_if ();

  tls_client_hello_sni_extract_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .payload_i (payload_if.sink),
    .cfg_i   (cfg_if.sink),
    .result_o  (result_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [7:0]   limit_reg;
  logic [16:0]  pos, rec_end, ext_end, sni_end;
  parse_phase_e phase, resume;
  logic [15:0]  remaining, acc;
  logic [7:0]   minor, emitted;
  logic [2:0]   pending;
  logic         major3, done;

  result_t      sni_results_q[$];
  payload_beat_t hello_bytes_q[$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  send_idle = 30, recv_idle = 60;
  int unsigned  hold_cycles = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic void clear_parse();
    pos = '0; rec_end = '0; ext_end = '0; sni_end = '0;
    phase = P_HDR; resume = P_HDR; remaining = '0; acc = '0;
    minor = '0; emitted = '0; pending = RSN_OK; major3 = 1'b0; done = 1'b0;
  endfunction

  function automatic void fail_to(input logic [2:0] r);
    pending = r;
    phase = P_TAIL;
  endfunction

  function automatic void go_to(input int unsigned q, input parse_phase_e ph);
    if (q <= pos) phase = ph;
    else begin
      remaining = 16'(q - pos);
      resume = ph;
      phase = P_SKIP;
    end
  endfunction

  function automatic void next_extension(input int unsigned q);
    if (q + 4 <= ext_end) go_to(q, P_XT_HI);
    else fail_to(RSN_NO_SNI);
  endfunction

  function automatic void next_name_entry(input int unsigned q);
    if (q + 3 < sni_end) go_to(q, P_NT);
    else fail_to(RSN_NO_SNI);
  endfunction

  // Advances the parser by one payload byte and queues the result, if any.
  function automatic void predict_sni(input logic [7:0] b, input logic last);
    int unsigned idx, len;
    logic name_out, verdict;
    logic [2:0] reason;
    result_t r;
    name_out = 1'b0; verdict = 1'b0; reason = RSN_OK;
    if (done) begin
      if (last) clear_parse();
      return;
    end
    idx = pos;
    pos = 17'(idx + 1);
    r = '0;
    case (phase)
      P_HDR: begin
        if (idx == 0) acc = b;
        else if (idx == 1) begin
          if (acc != CONTENT_HANDSHAKE) pending = RSN_NOT_HS;
          else if (b < MAJOR_SSL3) pending = RSN_OLD_VER;
          else pending = RSN_OK;
          major3 = (b == MAJOR_SSL3);
        end else if (idx == 2) minor = b;
        else if (idx == 3) acc = b;
        else begin
          rec_end = 17'({acc[7:0], b}) + 17'd5;
          if (pending != RSN_OK) begin
            verdict = 1'b1; reason = pending; phase = P_TAIL;
          end else if (rec_end < 6) fail_to(RSN_OVERRUN);
          else phase = P_HS_TYPE;
        end
      end
      P_HS_TYPE: begin
        if (b != HS_CLIENT_HELLO) fail_to(RSN_NOT_HELLO);
        else if (HELLO_FIXED_END + 1 > rec_end) fail_to(RSN_OVERRUN);
        else go_to(HELLO_FIXED_END, P_SID_LEN);
      end
      P_SID_LEN: begin
        if (pos + b + 2 > rec_end) fail_to(RSN_OVERRUN);
        else go_to(pos + b, P_CS_HI);
      end
      P_CS_HI, P_EXT_HI, P_XT_HI, P_XL_HI_SNI, P_XL_HI_OTH, P_NL_HI_HOST, P_NL_HI_OTH: begin
        acc = b;
        phase = parse_phase_e'(phase + 1);
      end
      P_CS_LO: begin
        len = {acc[7:0], b};
        if (pos + len + 1 > rec_end) fail_to(RSN_OVERRUN);
        else go_to(pos + len, P_CM_LEN);
      end
      P_CM_LEN: begin
        len = pos + b;
        if (len == rec_end && major3 && minor == 0) fail_to(RSN_SSL3_NOEXT);
        else if (len + 2 > rec_end) fail_to(RSN_OVERRUN);
        else go_to(len, P_EXT_HI);
      end
      P_EXT_LO: begin
        len = {acc[7:0], b};
        if (pos + len > rec_end) fail_to(RSN_OVERRUN);
        else begin
          ext_end = 17'(pos + len);
          next_extension(pos);
        end
      end
      P_XT_LO: phase = ({acc[7:0], b} == 0) ? P_XL_HI_SNI : P_XL_HI_OTH;
      P_XL_LO_SNI: begin
        len = {acc[7:0], b};
        if (pos + len > ext_end) fail_to(RSN_OVERRUN);
        else begin
          sni_end = 17'(pos + len);
          next_name_entry(pos + 2);
        end
      end
      P_XL_LO_OTH: next_extension(pos + {acc[7:0], b});
      P_NT: phase = (b == NAME_TYPE_HOST) ? P_NL_HI_HOST : P_NL_HI_OTH;
      P_NL_LO_HOST: begin
        len = {acc[7:0], b};
        if (pos + len > sni_end) fail_to(RSN_OVERRUN);
        else if (len == 0) fail_to(RSN_OK);
        else begin
          remaining = 16'(len); phase = P_EMIT;
        end
      end
      P_NL_LO_OTH: begin
        len = {acc[7:0], b};
        if (pos + len > sni_end) fail_to(RSN_OVERRUN);
        else next_name_entry(pos + len);
      end
      P_EMIT: begin
        if (emitted < limit_reg) begin
          name_out = 1'b1; r.name_byte = b; emitted++;
        end
        remaining--;
        if (remaining == 0) fail_to(RSN_OK);
      end
      P_SKIP: begin
        remaining--;
        if (remaining == 0) phase = resume;
      end
      default: ;
    endcase
    if (!verdict && pos >= 5 && pos == rec_end) begin
      verdict = 1'b1;
      reason = (phase == P_TAIL) ? pending : RSN_OVERRUN;
    end
    if (!verdict && last) begin
      verdict = 1'b1; reason = RSN_INCOMPLETE;
    end
    if (!name_out && !verdict) return;
    r.name_valid = name_out;
    if (verdict) begin
      r.verdict_valid = 1'b1;
      r.name_found = (reason == RSN_OK);
      r.name_length = emitted;
      r.fail_reason = reason;
      done = 1'b1;
      if (last) clear_parse();
    end
    sni_results_q.push_back(r);
  endfunction

  // Builds a ClientHello: an optional extension, then a server_name entry.
  task automatic build_hello(input int unsigned name_len, input logic broken);
    logic [7:0] body[$];
    logic [7:0] ext[$];
    int unsigned n, sid, k;
    body.delete(); ext.delete();
    // Some other extension first, sometimes.
    if ($urandom_range(1, 0)) begin
      n = $urandom_range(4, 0);
      ext.push_back(8'h00); ext.push_back(8'($urandom_range(40, 1)));
      ext.push_back(8'h00); ext.push_back(8'(n));
      repeat (n) ext.push_back(8'($urandom));
    end
    if ($urandom_range(9, 0) != 0) begin
      ext.push_back(8'h00); ext.push_back(8'h00);
      ext.push_back(8'((name_len + 5) >> 8)); ext.push_back(8'(name_len + 5));
      ext.push_back(8'((name_len + 3) >> 8)); ext.push_back(8'(name_len + 3));
      ext.push_back($urandom_range(7, 0) == 0 ? 8'h01 : NAME_TYPE_HOST);
      ext.push_back(8'(name_len >> 8)); ext.push_back(8'(name_len));
      repeat (name_len) ext.push_back(8'($urandom));
    end
    body.push_back(HS_CLIENT_HELLO);
    repeat (37) body.push_back(8'($urandom));
    sid = $urandom_range(4, 0);
    body.push_back(8'(sid));
    repeat (sid) body.push_back(8'($urandom));
    body.push_back(8'h00); body.push_back(8'h02);
    body.push_back(8'($urandom)); body.push_back(8'($urandom));
    body.push_back(8'h01); body.push_back(8'h00);
    body.push_back(8'(ext.size() >> 8)); body.push_back(8'(ext.size()));
    foreach (ext[i]) body.push_back(ext[i]);
    if (broken) begin
      k = $urandom_range(body.size() - 1, 0);
      body[k] = 8'($urandom);
    end
    n = body.size();
    if (broken && $urandom_range(1, 0)) n = $urandom_range(n + 3, 1);
    k = hello_bytes_q.size();
    push_byte(CONTENT_HANDSHAKE, 1'b0);
    push_byte(MAJOR_SSL3, 1'b0);
    push_byte(8'($urandom_range(4, 0)), 1'b0);
    push_byte(8'(n >> 8), 1'b0);
    push_byte(8'(n), 1'b0);
    foreach (body[i]) push_byte(body[i], 1'b0);
    repeat ($urandom_range(3, 0)) push_byte(8'($urandom), 1'b0);
    hello_bytes_q[hello_bytes_q.size() - 1].payload_last = 1'b1;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    payload_beat_t s;
    s.payload_byte = b;
    s.payload_last = last;
    hello_bytes_q.push_back(s);
  endtask

  // Sends queued bytes, then waits until every expected result is in.
  task automatic send_bytes();
    payload_beat_t s;
    while (hello_bytes_q.size() != 0) begin
      s = hello_bytes_q.pop_front();
      if ($urandom_range(99, 0) < send_idle) begin
        payload_if.valid <= 1'b0;
        @(posedge clk_i);
        while ($urandom_range(99, 0) < send_idle) @(posedge clk_i);
      end
      payload_if.valid <= 1'b1;
      payload_if.payload_byte <= s.payload_byte;
      payload_if.payload_last <= s.payload_last;
      @(posedge clk_i);
      while (!payload_if.ready) @(posedge clk_i);
      predict_sni(s.payload_byte, s.payload_last);
    end
    payload_if.valid <= 1'b0;
    while (sni_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.max_name_len <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    limit_reg = v;
  endtask

  // Receiver: random stalls plus one long hold-off.
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99, 0) >= recv_idle);
    end
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (sni_results_q.size() == 0) report("result with nothing expected");
      else begin
        e = sni_results_q.pop_front();
        if (result_if.name_valid !== e.name_valid) report("name_valid");
        if (result_if.name_byte !== e.name_byte) report("name_byte");
        if (result_if.verdict_valid !== e.verdict_valid) report("verdict_valid");
        if (result_if.name_found !== e.name_found) report("name_found");
        if (result_if.name_length !== e.name_length) report("name_length");
        if (result_if.fail_reason !== e.fail_reason) report("fail_reason");
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Directed rows: header bytes and, where obvious, the verdict they give.
  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       has_exp;
    logic [2:0] reason;
  } row_t;

  row_t rows[] = '{
    '{8'h80, 1'b0, 1'b0, RSN_OK}, '{8'h03, 1'b0, 1'b0, RSN_OK}, '{8'h01, 1'b0, 1'b0, RSN_OK},
    '{8'h00, 1'b0, 1'b0, RSN_OK}, '{8'h30, 1'b1, 1'b1, RSN_NOT_HS},
    '{8'h16, 1'b0, 1'b0, RSN_OK}, '{8'h02, 1'b0, 1'b0, RSN_OK}, '{8'h00, 1'b0, 1'b0, RSN_OK},
    '{8'hff, 1'b0, 1'b0, RSN_OK}, '{8'hff, 1'b1, 1'b1, RSN_OLD_VER},
    '{8'h16, 1'b0, 1'b0, RSN_OK}, '{8'hff, 1'b0, 1'b0, RSN_OK}, '{8'h03, 1'b0, 1'b0, RSN_OK},
    '{8'h00, 1'b0, 1'b0, RSN_OK}, '{8'h10, 1'b0, 1'b0, RSN_OK},
    '{8'h02, 1'b1, 1'b1, RSN_INCOMPLETE},
    '{8'h16, 1'b0, 1'b0, RSN_OK}, '{8'h03, 1'b0, 1'b0, RSN_OK}, '{8'h03, 1'b1, 1'b1, RSN_INCOMPLETE},
    '{8'h16, 1'b0, 1'b0, RSN_OK}, '{8'h03, 1'b0, 1'b0, RSN_OK}, '{8'h01, 1'b0, 1'b0, RSN_OK},
    '{8'h00, 1'b0, 1'b0, RSN_OK}, '{8'h00, 1'b1, 1'b1, RSN_OVERRUN}
  };

  initial begin
    int unsigned n_items;
    result_t r;
    payload_if.valid = 1'b0;
    payload_if.payload_byte = '0;
    payload_if.payload_last = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.max_name_len = '0;
    result_if.ready = 1'b0;
    limit_reg = MAX_NAME_RESET;
    clear_parse();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; typed verdicts must agree with the predictor.
    foreach (rows[i]) begin
      push_byte(rows[i].b, rows[i].last);
      if (rows[i].has_exp) begin
        r = '0;
        r.verdict_valid = 1'b1;
        r.name_found = (rows[i].reason == RSN_OK);
        r.fail_reason = rows[i].reason;
        send_bytes_prefix(r);
      end
    end
    send_bytes();
    write_limit(8'd0);
    build_hello(0, 1'b0);
    build_hello(3, 1'b0);
    send_bytes();
    write_limit(8'd1);
    build_hello(5, 1'b0);
    send_bytes();

    // Random phases with rotating limits and idling.
    n_items = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 30 : (ph == 1) ? 60 : 0;
      recv_idle = (ph == 0) ? 60 : (ph == 1) ? 30 : 0;
      write_limit(ph == 0 ? 8'd255 : ph == 1 ? 8'($urandom_range(12, 1)) : 8'd254);
      if (ph == 2) hold_cycles = 300;
      repeat (7) begin
        if ($urandom_range(4, 0) == 0) begin
          repeat ($urandom_range(20, 1)) push_byte(8'($urandom), 1'($urandom));
          push_byte(8'($urandom), 1'b1);
        end else begin
          build_hello($urandom_range(9, 0) == 0 ? $urandom_range(300, 20)
                                               : $urandom_range(16, 0),
                      $urandom_range(3, 0) == 0);
        end
        n_items += hello_bytes_q.size();
        send_bytes();
      end
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Checks a typed verdict against the predictor, then sends the bytes.
  task automatic send_bytes_prefix(input result_t typed);
    result_t p;
    send_bytes_peek(p);
    if (p != typed) report("directed verdict differs from predictor");
    send_bytes();
  endtask

  // Predicts the queued bytes to peek the verdict, then restores saved state.
  task automatic send_bytes_peek(output result_t v);
    int unsigned n0;
    logic [16:0] s_pos, s_re; parse_phase_e s_ph; logic [7:0] s_min; logic [2:0] s_pend;
    logic [15:0] s_acc; logic s_m3, s_done;
    s_pos = pos; s_re = rec_end; s_ph = phase; s_min = minor; s_pend = pending;
    s_acc = acc; s_m3 = major3; s_done = done;
    n0 = sni_results_q.size();
    foreach (hello_bytes_q[i]) predict_sni(hello_bytes_q[i].payload_byte,
                                           hello_bytes_q[i].payload_last);
    v = sni_results_q[sni_results_q.size() - 1];
    while (sni_results_q.size() > n0) void'(sni_results_q.pop_back());
    pos = s_pos; rec_end = s_re; phase = s_ph; minor = s_min; pending = s_pend;
    acc = s_acc; major3 = s_m3; done = s_done;
  endtask

endmodule
